// ===== design/jseu_pkg.sv =====
// Package for the JSON string escape / UTF-8 check unit.
// Shared constants, queue word types and escape helper functions. No dependencies.
package jseu_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int LIMIT_BITS = 16;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd4096;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PLAIN = 2'd1;
    localparam logic [1:0] KIND_ESC2  = 2'd2;
    localparam logic [1:0] KIND_ESC6  = 2'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_A      = 8'h61;

    typedef struct packed {
        logic       open;
        logic [1:0] kind;
        logic [7:0] body;
        logic       close;
        logic       err;
        logic       ovf;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // second char of a two-char escape, zero if none
    function automatic logic [7:0] esc_char(input logic [7:0] b);
        logic [7:0] c;
        case (b)
            8'h22:   c = CH_QUOTE;
            8'h5C:   c = CH_BSLASH;
            8'h08:   c = 8'h62;
            8'h0C:   c = 8'h66;
            8'h0A:   c = 8'h6E;
            8'h0D:   c = 8'h72;
            8'h09:   c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = CH_ZERO + {4'd0, nib};
        end
        else
        begin
            c = CH_A + {4'd0, nib - 4'd10};
        end
        return c;
    endfunction

endpackage

// ===== design/jseu_if.sv =====
// Handshake interfaces for source bytes and encoded output bytes.
// Depends on nothing; used by the unit's modules.
interface jseu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       is_first;
    logic       is_last;
    logic       no_byte;

    modport source(output valid, output byte_value, output is_first, output is_last,
                   output no_byte, input ready);
    modport sink(input valid, input byte_value, input is_first, input is_last,
                 input no_byte, output ready);
endinterface

interface jseu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;
    logic       string_end;
    logic       utf8_error;
    logic       budget_overflow;

    modport source(output valid, output out_char, output run_last, output string_end,
                   output utf8_error, output budget_overflow, input ready);
    modport sink(input valid, input out_char, input run_last, input string_end,
                 input utf8_error, input budget_overflow, output ready);
endinterface

// ===== design/jseu_front.sv =====
// Front end: accepts source words, runs the UTF-8 check and the byte budget,
// and pushes at most one job per word into the queue. Uses jseu_pkg and jseu_in_if.
module jseu_front #(
    parameter int COUNT_BITS = jseu_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [jseu_pkg::LIMIT_BITS-1:0]    output_limit,
    jseu_in_if.sink                            raw,
    input  jseu_pkg::qstat_t                   qstat,
    output jseu_pkg::push_t                    push
);
    import jseu_pkg::*;

    localparam int CW = ((COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS) + 1;
    localparam logic [CW-1:0] CNT_MAX = CW'({COUNT_BITS{1'b1}});

    logic [1:0]            cont_reg, cont_next;
    logic [20:0]           acc_reg, acc_next;
    logic [2:0]            seq_reg, seq_next;
    logic                  bad_reg, bad_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  ovf_reg, ovf_next;

    logic                  accept;
    logic [7:0]            b;
    logic [7:0]            esc;
    logic [1:0]            kind;
    logic [2:0]            blen;
    logic [CW-1:0]         lim_w;
    logic [CW-1:0]         cnt1, sum_b, cnt2;
    logic                  ovf1, ovf2, ovf3;
    logic                  fits, emit;
    logic [1:0]            c0, c1;
    logic [20:0]           a0, a1;
    logic [2:0]            s0, s1;
    logic                  bd0, bd1, bad_end;

    assign raw.ready = !qstat.full;
    assign accept    = raw.valid && !qstat.full;
    assign b         = raw.byte_value;
    assign esc       = esc_char(b);
    assign lim_w     = CW'(output_limit);

    always_comb
    begin
        if (esc != 8'h00)
        begin
            kind = KIND_ESC2;
            blen = 3'd2;
        end
        else if (b < 8'h20)
        begin
            kind = KIND_ESC6;
            blen = 3'd6;
        end
        else
        begin
            kind = KIND_PLAIN;
            blen = 3'd1;
        end
    end

    // budget
    always_comb
    begin
        cnt1  = raw.is_first ? CW'(1) : CW'(cnt_reg);
        ovf1  = raw.is_first ? (output_limit == '0) : ovf_reg;
        sum_b = cnt1 + CW'(blen);
        fits  = !ovf1 && (sum_b <= lim_w);
        emit  = !raw.no_byte && fits;
        if (emit)
        begin
            cnt2 = (sum_b > CNT_MAX) ? CNT_MAX : sum_b;
        end
        else
        begin
            cnt2 = cnt1;
        end
        ovf2 = ovf1 || (!raw.no_byte && !fits);
        ovf3 = ovf2 || ((cnt2 + CW'(1)) > lim_w);
    end

    // UTF-8 check
    always_comb
    begin
        c0 = raw.is_first ? 2'd0  : cont_reg;
        a0 = raw.is_first ? 21'd0 : acc_reg;
        s0 = raw.is_first ? 3'd0  : seq_reg;
        bd0 = raw.is_first ? 1'b0 : bad_reg;
        c1 = c0;
        a1 = a0;
        s1 = s0;
        bd1 = bd0;
        if (!raw.no_byte)
        begin
            if ((c0 != 2'd0) && (b[7:6] == 2'b10))
            begin
                a1 = {a0[14:0], b[5:0]};
                c1 = c0 - 2'd1;
                if (c1 == 2'd0)
                begin
                    if (((s0 == 3'd2) && (a1 < 21'h80)) ||
                        ((s0 == 3'd3) && (a1 < 21'h800)) ||
                        ((s0 == 3'd4) && (a1 < 21'h10000)) ||
                        (a1 > 21'h10FFFF) ||
                        ((a1 >= 21'hD800) && (a1 <= 21'hDFFF)))
                    begin
                        bd1 = 1'b1;
                    end
                end
            end
            else
            begin
                if (c0 != 2'd0)
                begin
                    bd1 = 1'b1;
                    c1 = 2'd0;
                end
                if (b <= 8'h7F)
                begin
                    s1 = 3'd1;
                end
                else if ((b >= 8'hC2) && (b <= 8'hDF))
                begin
                    s1 = 3'd2;
                    c1 = 2'd1;
                    a1 = {16'd0, b[4:0]};
                end
                else if ((b >= 8'hE0) && (b <= 8'hEF))
                begin
                    s1 = 3'd3;
                    c1 = 2'd2;
                    a1 = {17'd0, b[3:0]};
                end
                else if ((b >= 8'hF0) && (b <= 8'hF4))
                begin
                    s1 = 3'd4;
                    c1 = 2'd3;
                    a1 = {18'd0, b[2:0]};
                end
                else
                begin
                    bd1 = 1'b1;
                    s1 = 3'd0;
                end
            end
        end
        bad_end = bd1 || (raw.is_last && (c1 != 2'd0));
    end

    always_comb
    begin
        cont_next = cont_reg;
        acc_next  = acc_reg;
        seq_next  = seq_reg;
        bad_next  = bad_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        if (accept)
        begin
            if (raw.is_last)
            begin
                cont_next = '0;
                acc_next  = '0;
                seq_next  = '0;
                bad_next  = 1'b0;
                cnt_next  = '0;
                ovf_next  = 1'b0;
            end
            else
            begin
                cont_next = c1;
                acc_next  = a1;
                seq_next  = s1;
                bad_next  = bd1;
                cnt_next  = cnt2[COUNT_BITS-1:0];
                ovf_next  = ovf2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_reg <= '0;
            acc_reg  <= '0;
            seq_reg  <= '0;
            bad_reg  <= 1'b0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            cont_reg <= cont_next;
            acc_reg  <= acc_next;
            seq_reg  <= seq_next;
            bad_reg  <= bad_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_comb
    begin
        push.valid     = accept && (raw.is_first || emit || raw.is_last);
        push.job.open  = raw.is_first;
        push.job.kind  = emit ? kind : KIND_NONE;
        push.job.body  = (esc != 8'h00) ? esc : b;
        push.job.close = raw.is_last;
        push.job.err   = bad_end;
        push.job.ovf   = ovf3;
    end

endmodule

// ===== design/jseu_queue.sv =====
// Short job queue between front and back end.
// Uses jseu_pkg for the job word and status types.
module jseu_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  jseu_pkg::push_t  push,
    input  logic             pop,
    output jseu_pkg::job_t   head,
    output jseu_pkg::qstat_t qstat
);
    import jseu_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam logic [QAW:0] QFULL = (QAW + 1)'(QUEUE_DEPTH);

    job_t           mem [QUEUE_DEPTH];
    logic [QAW-1:0] wr_reg, wr_next;
    logic [QAW-1:0] rd_reg, rd_next;
    logic [QAW:0]   cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign qstat.full  = (cnt_reg == QFULL);
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push.valid && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/jseu_back.sv =====
// Back end: expands the queue head job into output bytes, one per cycle while enc
// is ready, through an output register. Uses jseu_pkg and jseu_out_if.
module jseu_back (
    input  logic             clk,
    input  logic             rst_n,
    input  jseu_pkg::job_t   head,
    input  jseu_pkg::qstat_t qstat,
    output logic             pop,
    jseu_out_if.source       enc
);
    import jseu_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic       vld_reg, vld_next;
    logic [7:0] char_reg, char_next;
    logic       runl_reg, runl_next;
    logic       end_reg, end_next;
    logic       err_reg, err_next;
    logic       ovf_reg, ovf_next;

    logic       take, load;
    logic [2:0] blen;
    logic [3:0] n;
    logic [2:0] last_pos;
    logic       at_last;
    logic [2:0] rel;
    logic [7:0] ch;

    function automatic logic [7:0] body_char(input job_t j, input logic [2:0] r);
        logic [7:0] c;
        case (j.kind)
            KIND_ESC2:
            begin
                c = (r == 3'd0) ? CH_BSLASH : j.body;
            end
            KIND_ESC6:
            begin
                case (r)
                    3'd0:    c = CH_BSLASH;
                    3'd1:    c = CH_U;
                    3'd2:    c = CH_ZERO;
                    3'd3:    c = CH_ZERO;
                    3'd4:    c = hex_digit(j.body[7:4]);
                    default: c = hex_digit(j.body[3:0]);
                endcase
            end
            default:
            begin
                c = j.body;
            end
        endcase
        return c;
    endfunction

    always_comb
    begin
        case (head.kind)
            KIND_PLAIN: blen = 3'd1;
            KIND_ESC2:  blen = 3'd2;
            KIND_ESC6:  blen = 3'd6;
            default:    blen = 3'd0;
        endcase
    end

    assign n        = {3'd0, head.open} + {1'b0, blen} + {3'd0, head.close};
    assign last_pos = 3'(n - 4'd1);
    assign at_last  = (pos_reg == last_pos);
    assign rel      = pos_reg - {2'd0, head.open};
    assign take     = !vld_reg || enc.ready;
    assign load     = take && !qstat.empty;
    assign pop      = load && at_last;

    always_comb
    begin
        if (head.open && (pos_reg == 3'd0))
        begin
            ch = CH_QUOTE;
        end
        else if (rel < blen)
        begin
            ch = body_char(head, rel);
        end
        else
        begin
            ch = CH_QUOTE;
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        vld_next  = vld_reg;
        char_next = char_reg;
        runl_next = runl_reg;
        end_next  = end_reg;
        err_next  = err_reg;
        ovf_next  = ovf_reg;
        if (take)
        begin
            vld_next = load;
        end
        if (load)
        begin
            pos_next  = at_last ? 3'd0 : pos_reg + 3'd1;
            char_next = ch;
            runl_next = at_last;
            end_next  = at_last && head.close;
            err_next  = at_last && head.close && head.err;
            ovf_next  = at_last && head.close && head.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        runl_reg <= runl_next;
        end_reg  <= end_next;
        err_reg  <= err_next;
        ovf_reg  <= ovf_next;
    end

    assign enc.valid           = vld_reg;
    assign enc.out_char        = char_reg;
    assign enc.run_last        = runl_reg;
    assign enc.string_end      = end_reg;
    assign enc.utf8_error      = err_reg;
    assign enc.budget_overflow = ovf_reg;

endmodule

// ===== design/json_string_escape_utf8_check_unit.sv =====
// Top level of the JSON string escape unit with UTF-8 check and byte budget.
// Holds output_limit; uses jseu_pkg, jseu_if, jseu_front, jseu_queue, jseu_back.
//
//  channel  | dir | handshake        | word
//  ---------+-----+------------------+------------------------------------------
//  raw      | in  | valid/ready      | byte_value, is_first, is_last, no_byte
//  enc      | out | valid/ready      | out_char, run_last, string_end, flags
//  cfg      | in  | cfg_we           | cfg_wdata -> output_limit
//
// A source word is accepted every cycle while the 4-job queue is not full; its
// first output byte passes the queue and the back end's output register to enc.
// The back end sends one byte per cycle while enc is ready: 0..8 bytes a word
// (6 for a \u00hh escape). Reset sets output_limit to 4096 and clears string
// state and queue; no clearing pass. Output stalls back up the queue to raw.ready.
module json_string_escape_utf8_check_unit #(
    parameter int COUNT_BITS = jseu_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [jseu_pkg::LIMIT_BITS-1:0] cfg_wdata,
    jseu_in_if.sink                         raw,
    jseu_out_if.source                      enc
);
    import jseu_pkg::*;

    logic [LIMIT_BITS-1:0] limit_reg, limit_next;
    push_t                 push;
    job_t                  head;
    qstat_t                qstat;
    logic                  pop;

    assign limit_next = cfg_we ? cfg_wdata : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    jseu_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .output_limit (limit_reg),
        .raw          (raw),
        .qstat        (qstat),
        .push         (push)
    );

    jseu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    jseu_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .qstat (qstat),
        .pop   (pop),
        .enc   (enc)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !push.valid)
        else $error("job pushed into full queue");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (enc.valid && enc.string_end) |-> enc.run_last)
        else $error("closing quote not last of its word");

    a_flags_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (enc.valid && !enc.string_end) |-> (!enc.utf8_error && !enc.budget_overflow))
        else $error("verdict flags off the closing quote");

    a_quote_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (raw.valid && raw.ready && (raw.is_first || raw.is_last)) |=> !qstat.empty)
        else $error("quote word not queued");

endmodule

// ===== sim/json_string_escape_utf8_check_unit_test.sv =====
// Self-checking testbench for json_string_escape_utf8_check_unit: predicts the escaped
// output words and verdict flags for each accepted source word and scores them in order.
// Depends on jseu_pkg, jseu_in_if / jseu_out_if and the unit's RTL.
`timescale 1ns / 100ps

module json_string_escape_utf8_check_unit_test;
    import jseu_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       first;
        logic       last;
        logic       none;
    } raw_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       string_end;
        logic       utf8_error;
        logic       budget_overflow;
    } enc_word_t;

    localparam logic [7:0] BACKSPACE       = 8'h08;
    localparam logic [7:0] TAB             = 8'h09;
    localparam logic [7:0] LINE_FEED       = 8'h0A;
    localparam logic [7:0] FORM_FEED       = 8'h0C;
    localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;
    localparam logic [7:0] SPACE           = 8'h20;
    localparam logic [7:0] CH_LOWER_B      = 8'h62;
    localparam logic [7:0] CH_LOWER_F      = 8'h66;
    localparam logic [7:0] CH_LOWER_N      = 8'h6E;
    localparam logic [7:0] CH_LOWER_R      = 8'h72;
    localparam logic [7:0] CH_LOWER_T      = 8'h74;
    localparam int COUNT_MAX     = (1 << COUNT_BITS_DEF) - 1;
    localparam int RANDOM_ITEMS  = 200;
    localparam int PHASE_ITEMS   = 30;
    localparam int DRAIN_CYCLES  = 16;
    localparam int FILL_ESCAPES  = 2;
    localparam int MAX_REPORTS   = 10;

    class enc_scoreboard;
        logic [15:0] limit;
        logic [1:0]  cont_left;
        logic [20:0] scalar;
        logic [2:0]  seq_len;
        bit          bad;
        int          emitted;
        bit          ovf;
        enc_word_t   expected_q[$];
        int          mismatches;

        function new();
            limit = LIMIT_RESET;
            mismatches = 0;
            clear_string();
        endfunction

        function void clear_string();
            cont_left = '0;
            scalar = '0;
            seq_len = '0;
            bad = 1'b0;
            emitted = 0;
            ovf = 1'b0;
        endfunction

        function void add_expected(enc_word_t w);
            expected_q.insert(expected_q.size(), w);
        endfunction

        function void add_count(int n);
            emitted = (emitted + n > COUNT_MAX) ? COUNT_MAX : emitted + n;
        endfunction

        function void count_quote();
            if (emitted + 1 > int'(limit))
            begin
                ovf = 1'b1;
            end
            add_count(1);
        endfunction

        function logic [7:0] hex_char(logic [3:0] nib);
            return (nib < 4'd10) ? CH_ZERO + 8'(nib) : CH_A + 8'(nib) - 8'd10;
        endfunction

        function int encode_byte(input logic [7:0] b, output logic [5:0][7:0] piece);
            logic [7:0] c;
            piece = '0;
            case (b)
                CH_QUOTE:        c = CH_QUOTE;
                CH_BSLASH:       c = CH_BSLASH;
                BACKSPACE:       c = CH_LOWER_B;
                FORM_FEED:       c = CH_LOWER_F;
                LINE_FEED:       c = CH_LOWER_N;
                CARRIAGE_RETURN: c = CH_LOWER_R;
                TAB:             c = CH_LOWER_T;
                default:         c = 8'h00;
            endcase
            if (c != 8'h00)
            begin
                piece[0] = CH_BSLASH;
                piece[1] = c;
                return 2;
            end
            if (b < SPACE)
            begin
                piece[0] = CH_BSLASH;
                piece[1] = CH_U;
                piece[2] = CH_ZERO;
                piece[3] = CH_ZERO;
                piece[4] = hex_char(b[7:4]);
                piece[5] = hex_char(b[3:0]);
                return 6;
            end
            piece[0] = b;
            return 1;
        endfunction

        function void check_lead(logic [7:0] b);
            if (b <= 8'h7F)
            begin
                seq_len = 3'd1;
            end
            else if (b >= 8'hC2 && b <= 8'hDF)
            begin
                seq_len = 3'd2;
                cont_left = 2'd1;
                scalar = {16'd0, b[4:0]};
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                seq_len = 3'd3;
                cont_left = 2'd2;
                scalar = {17'd0, b[3:0]};
            end
            else if (b >= 8'hF0 && b <= 8'hF4)
            begin
                seq_len = 3'd4;
                cont_left = 2'd3;
                scalar = {18'd0, b[2:0]};
            end
            else
            begin
                bad = 1'b1;
                seq_len = 3'd0;
            end
        endfunction

        function void check_utf8(logic [7:0] b);
            if (cont_left != 2'd0 && b[7:6] == 2'b10)
            begin
                scalar = {scalar[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0 &&
                    ((seq_len == 3'd2 && scalar < 21'h80) ||
                     (seq_len == 3'd3 && scalar < 21'h800) ||
                     (seq_len == 3'd4 && scalar < 21'h10000) ||
                     scalar > 21'h10FFFF ||
                     (scalar >= 21'hD800 && scalar <= 21'hDFFF)))
                begin
                    bad = 1'b1;
                end
            end
            else
            begin
                if (cont_left != 2'd0)
                begin
                    bad = 1'b1;
                    cont_left = 2'd0;
                end
                check_lead(b);
            end
        endfunction

        function void note_input(logic [7:0] b, logic first, logic last, logic none);
            logic [5:0][7:0] piece;
            int n;
            int start;
            start = expected_q.size();
            if (first)
            begin
                clear_string();
                count_quote();
                add_expected('{CH_QUOTE, 1'b0, 1'b0, 1'b0, 1'b0});
            end
            if (!none)
            begin
                n = encode_byte(b, piece);
                check_utf8(b);
                if (!ovf && emitted + n <= int'(limit))
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        add_expected('{piece[i], 1'b0, 1'b0, 1'b0, 1'b0});
                    end
                    add_count(n);
                end
                else
                begin
                    ovf = 1'b1;
                end
            end
            if (last)
            begin
                if (cont_left != 2'd0)
                begin
                    bad = 1'b1;
                end
                count_quote();
                add_expected('{CH_QUOTE, 1'b0, 1'b1, bad, ovf});
                clear_string();
            end
            if (expected_q.size() > start)
            begin
                expected_q[expected_q.size() - 1].run_last = 1'b1;
            end
        endfunction

        function void check_result(enc_word_t got);
            enc_word_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected word: char %h last %b end %b utf8 %b ovf %b",
                             got.out_char, got.run_last, got.string_end,
                             got.utf8_error, got.budget_overflow);
                end
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("word mismatch: expected char %h last %b end %b utf8 %b ovf %b",
                                 want.out_char, want.run_last, want.string_end,
                                 want.utf8_error, want.budget_overflow);
                        $display("                    got char %h last %b end %b utf8 %b ovf %b",
                                 got.out_char, got.run_last, got.string_end,
                                 got.utf8_error, got.budget_overflow);
                    end
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void finish_check();
            if (expected_q.size() != 0)
            begin
                mismatches++;
                $display("%0d expected words never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    bit          steady;
    int          sent_count;
    enc_scoreboard sb;

    jseu_in_if  raw_if();
    jseu_out_if enc_if();

    json_string_escape_utf8_check_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .raw       (raw_if),
        .enc       (enc_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range('h80, 'hBF));
    endfunction

    function automatic void add_text(ref logic [7:0] q[$], input logic [7:0] v);
        q.insert(q.size(), v);
    endfunction

    function automatic void add_item(ref raw_word_t q[$], input raw_word_t w);
        q.insert(q.size(), w);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic first, input logic last,
                             input logic none);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            raw_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        raw_if.valid <= 1'b1;
        raw_if.byte_value <= b;
        raw_if.is_first <= first;
        raw_if.is_last <= last;
        raw_if.no_byte <= none;
        do @(posedge clk); while (raw_if.ready !== 1'b1);
        sb.note_input(b, first, last, none);
        sent_count++;
    endtask

    task automatic drain();
        raw_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.limit = value;
    endtask

    initial
    begin : enc_sink
        int gap;
        enc_word_t got;
        enc_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                enc_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            enc_if.ready <= 1'b1;
            do @(posedge clk); while (enc_if.valid !== 1'b1);
            got.out_char = enc_if.out_char;
            got.run_last = enc_if.run_last;
            got.string_end = enc_if.string_end;
            got.utf8_error = enc_if.utf8_error;
            got.budget_overflow = enc_if.budget_overflow;
            sb.check_result(got);
        end
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int phase_start;
        int kind;
        int need;
        logic [7:0] lead;
        logic [7:0] text_q[$];
        raw_word_t items[$];
        bit open_str;
        bit close_str;
        sb = new();
        steady = 1'b0;
        sent_count = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        raw_if.valid <= 1'b0;
        raw_if.byte_value <= '0;
        raw_if.is_first <= 1'b0;
        raw_if.is_last <= 1'b0;
        raw_if.no_byte <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed, at the reset limit
        send_word("x", 1'b0, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0, 1'b1);
        send_word(8'hA5, 1'b1, 1'b1, 1'b1);
        send_word(CH_QUOTE, 1'b1, 1'b0, 1'b0);
        send_word(CH_BSLASH, 1'b0, 1'b0, 1'b0);
        send_word(BACKSPACE, 1'b0, 1'b0, 1'b0);
        send_word(FORM_FEED, 1'b0, 1'b0, 1'b0);
        send_word(LINE_FEED, 1'b0, 1'b0, 1'b0);
        send_word(CARRIAGE_RETURN, 1'b0, 1'b0, 1'b0);
        send_word(TAB, 1'b0, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0, 1'b0);
        send_word(8'h1F, 1'b0, 1'b0, 1'b0);
        send_word(8'h7F, 1'b0, 1'b0, 1'b0);
        send_word(SPACE, 1'b0, 1'b1, 1'b0);
        send_word(8'hC3, 1'b1, 1'b0, 1'b0);
        send_word(8'hA9, 1'b0, 1'b1, 1'b0);
        send_word(8'hED, 1'b1, 1'b0, 1'b0);
        send_word(8'hA0, 1'b0, 1'b0, 1'b0);
        send_word(8'h80, 1'b0, 1'b1, 1'b0);
        send_word(8'hE2, 1'b1, 1'b0, 1'b0);
        send_word(8'h82, 1'b0, 1'b1, 1'b0);
        send_word(8'hF4, 1'b1, 1'b0, 1'b0);
        send_word(8'h8F, 1'b0, 1'b0, 1'b0);
        send_word(8'hBF, 1'b0, 1'b0, 1'b0);
        send_word(8'hBF, 1'b0, 1'b1, 1'b0);

        phase = 0;
        phase_start = sent_count;
        while (sent_count - phase_start < RANDOM_ITEMS)
        begin : random_phase
            int limit_start;
            drain();
            if (phase == 0)
                set_limit(16'd2);
            else if (phase == 1)
                set_limit(16'hFFFF);
            else
            begin
                case ($urandom_range(0, 3))
                    0:       set_limit(16'($urandom_range(3, 12)));
                    1:       set_limit(16'($urandom_range(13, 48)));
                    2:       set_limit(16'($urandom_range(49, 400)));
                    default: set_limit(16'($urandom_range(2, 65535)));
                endcase
            end
            limit_start = sent_count;
            while (sent_count - limit_start < PHASE_ITEMS)
            begin
                text_q.delete();
                items.delete();
                steady = ($urandom_range(0, 5) == 0);
                repeat ($urandom_range(0, 5))
                begin
                    kind = $urandom_range(0, 15);
                    case (kind)
                        0, 1, 2:
                            repeat ($urandom_range(1, 3))
                                add_text(text_q, 8'($urandom_range(32, 126)));
                        3:
                            add_text(text_q, 8'($urandom_range(0, 31)));
                        4:
                            add_text(text_q, $urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH);
                        5, 6:
                        begin
                            add_text(text_q, 8'($urandom_range('hC2, 'hDF)));
                            add_text(text_q, cont_byte());
                        end
                        7, 8:
                        begin
                            lead = 8'($urandom_range('hE0, 'hEF));
                            add_text(text_q, lead);
                            if (lead == 8'hE0)
                                add_text(text_q, 8'($urandom_range('hA0, 'hBF)));
                            else if (lead == 8'hED)
                                add_text(text_q, 8'($urandom_range('h80, 'h9F)));
                            else
                                add_text(text_q, cont_byte());
                            add_text(text_q, cont_byte());
                        end
                        9:
                        begin
                            lead = 8'($urandom_range('hF0, 'hF4));
                            add_text(text_q, lead);
                            if (lead == 8'hF0)
                                add_text(text_q, 8'($urandom_range('h90, 'hBF)));
                            else if (lead == 8'hF4)
                                add_text(text_q, 8'($urandom_range('h80, 'h8F)));
                            else
                                add_text(text_q, cont_byte());
                            add_text(text_q, cont_byte());
                            add_text(text_q, cont_byte());
                        end
                        10:
                            add_text(text_q, 8'($urandom_range(0, 255)));
                        11:
                        begin
                            // overlong forms
                            case ($urandom_range(0, 2))
                                0:
                                begin
                                    add_text(text_q, 8'($urandom_range('hC0, 'hC1)));
                                    add_text(text_q, cont_byte());
                                end
                                1:
                                begin
                                    add_text(text_q, 8'hE0);
                                    add_text(text_q, 8'($urandom_range('h80, 'h9F)));
                                    add_text(text_q, cont_byte());
                                end
                                default:
                                begin
                                    add_text(text_q, 8'hF0);
                                    add_text(text_q, 8'($urandom_range('h80, 'h8F)));
                                    add_text(text_q, cont_byte());
                                    add_text(text_q, cont_byte());
                                end
                            endcase
                        end
                        12:
                        begin
                            add_text(text_q, 8'hED);
                            add_text(text_q, 8'($urandom_range('hA0, 'hBF)));
                            add_text(text_q, cont_byte());
                        end
                        13:
                        begin
                            add_text(text_q, 8'hF4);
                            add_text(text_q, 8'($urandom_range('h90, 'hBF)));
                            add_text(text_q, cont_byte());
                            add_text(text_q, cont_byte());
                        end
                        14:
                        begin
                            // sequence cut short
                            lead = 8'($urandom_range('hC2, 'hF4));
                            need = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
                            add_text(text_q, lead);
                            repeat ($urandom_range(0, need - 1))
                                add_text(text_q, cont_byte());
                        end
                        default:
                        begin
                            if ($urandom_range(0, 1))
                                add_text(text_q, cont_byte());
                            else
                                add_text(text_q, 8'($urandom_range('hF5, 'hFF)));
                        end
                    endcase
                end
                foreach (text_q[i])
                begin
                    if ($urandom_range(0, 11) == 0)
                        add_item(items, '{8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1});
                    add_item(items, '{text_q[i], 1'b0, 1'b0, 1'b0});
                end
                open_str = ($urandom_range(0, 7) != 0);
                close_str = ($urandom_range(0, 7) != 0);
                if (open_str)
                begin
                    if (items.size() == 0 || $urandom_range(0, 3) == 0)
                        items.push_front('{8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b1});
                    else
                        items[0].first = 1'b1;
                end
                if (close_str)
                begin
                    if (items.size() == 0 || $urandom_range(0, 3) == 0)
                        add_item(items, '{8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1});
                    else
                        items[items.size() - 1].last = 1'b1;
                end
                foreach (items[i])
                    send_word(items[i].b, items[i].first, items[i].last, items[i].none);
            end
            phase++;
        end

        // fill the budget exactly, then overflow on a further escape before the closing quote
        drain();
        set_limit(16'(1 + 6 * FILL_ESCAPES + 2));
        steady = 1'b1;
        send_word(8'h01, 1'b1, 1'b0, 1'b0);
        repeat (FILL_ESCAPES - 1) send_word(8'h01, 1'b0, 1'b0, 1'b0);
        send_word("a", 1'b0, 1'b0, 1'b0);
        send_word("b", 1'b0, 1'b0, 1'b0);
        send_word(8'h02, 1'b0, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1, 1'b1);

        drain();
        sb.finish_check();
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
